@@ rtl/core/psv_pkg.sv @@
// Shared types, constants and helpers for the plucked string voice.
// Used by the register block, controller, datapath and top level.
package psv_pkg;

	localparam int MAX_DELAY = 4096;
	localparam int ADDR_W    = 12;
	localparam int LEN_W     = 13;
	localparam int SAMPLE_W  = 16;
	localparam int CNT_W     = 24;

	localparam logic [LEN_W-1:0]    LEN_MIN   = 13'd2;
	localparam logic [LEN_W-1:0]    LEN_MAX   = 13'd4096;
	localparam logic [15:0]         DECAY_Q16 = 16'd65503;
	localparam logic [CNT_W-1:0]    CNT_SAT   = 24'hFF_FFFF;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	localparam logic [2:0] REG_DELAY_LEN = 3'd0;
	localparam logic [2:0] REG_AP_COEFF  = 3'd1;
	localparam logic [2:0] REG_DAMPING   = 3'd2;
	localparam logic [2:0] REG_FLOOR     = 3'd3;
	localparam logic [2:0] REG_MIN_RING  = 3'd4;
	localparam logic [2:0] REG_MAX_RING  = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic [LEN_W-1:0] delay_length;
		logic [15:0]      allpass_coeff;
		logic [15:0]      damping;
		logic [14:0]      silence_floor;
		logic [CNT_W-1:0] min_ring;
		logic [CNT_W-1:0] max_ring;
	} cfg_t;

	typedef struct packed {
		logic rd_en;
		logic load_wr;
		logic start;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

	function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [19:0] v);
		logic signed [19:0] hi;
		logic signed [19:0] lo;
		hi = 20'sd32767;
		lo = -20'sd32768;
		if (v > hi) begin
			return 16'sh7FFF;
		end else if (v < lo) begin
			return 16'sh8000;
		end
		return v[SAMPLE_W-1:0];
	endfunction

endpackage

@@ rtl/core/psv_cfg.sv @@
// APB-style configuration registers of the plucked string voice.
// Depends on psv_pkg for the register indexes and the cfg_t bundle.
module psv_cfg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [4:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output psv_pkg::cfg_t         cfg
);

	psv_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [2:0]    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_length  <= 13'd2;
			cfg_q.allpass_coeff <= 16'd32768;
			cfg_q.damping       <= 16'd65208;
			cfg_q.silence_floor <= 15'd3;
			cfg_q.min_ring      <= 24'd4800;
			cfg_q.max_ring      <= 24'd960000;
		end else if (wr_en) begin
			case (reg_idx)
				psv_pkg::REG_DELAY_LEN: cfg_q.delay_length  <= pwdata[12:0];
				psv_pkg::REG_AP_COEFF:  cfg_q.allpass_coeff <= pwdata[15:0];
				psv_pkg::REG_DAMPING:   cfg_q.damping       <= pwdata[15:0];
				psv_pkg::REG_FLOOR:     cfg_q.silence_floor <= pwdata[14:0];
				psv_pkg::REG_MIN_RING:  cfg_q.min_ring      <= pwdata[23:0];
				psv_pkg::REG_MAX_RING:  cfg_q.max_ring      <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			psv_pkg::REG_DELAY_LEN: prdata = {19'd0, cfg_q.delay_length};
			psv_pkg::REG_AP_COEFF:  prdata = {16'd0, cfg_q.allpass_coeff};
			psv_pkg::REG_DAMPING:   prdata = {16'd0, cfg_q.damping};
			psv_pkg::REG_FLOOR:     prdata = {17'd0, cfg_q.silence_floor};
			psv_pkg::REG_MIN_RING:  prdata = {8'd0, cfg_q.min_ring};
			psv_pkg::REG_MAX_RING:  prdata = {8'd0, cfg_q.max_ring};
			default:                prdata = 32'd0;
		endcase
	end

endmodule

@@ rtl/core/psv_ctrl.sv @@
// Sequencing state machine of the plucked string voice.
// Depends on psv_pkg; drives cmd_t to psv_dpath and reads its status_t.
module psv_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        in_kind,
	output logic              in_ready,
	input  psv_pkg::status_t  status,
	output psv_pkg::cmd_t     cmd
);

	psv_pkg::state_t state_q;
	psv_pkg::state_t state_nx;
	logic            in_xfer;

	assign in_xfer = in_valid && (state_q == psv_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psv_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			psv_pkg::ST_IDLE: begin
				if (in_xfer && in_kind == psv_pkg::KIND_TICK) state_nx = psv_pkg::ST_MUL1;
			end
			psv_pkg::ST_MUL1:   state_nx = psv_pkg::ST_MUL2;
			psv_pkg::ST_MUL2:   state_nx = psv_pkg::ST_COMMIT;
			psv_pkg::ST_COMMIT: begin
				if (status.out_free) state_nx = psv_pkg::ST_IDLE;
			end
			default:            state_nx = psv_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = (state_q == psv_pkg::ST_IDLE);
		cmd.rd_en   = in_xfer && (in_kind == psv_pkg::KIND_TICK);
		cmd.load_wr = in_xfer && (in_kind == psv_pkg::KIND_LOAD);
		cmd.start   = in_xfer && (in_kind == psv_pkg::KIND_START);
		cmd.commit  = (state_q == psv_pkg::ST_COMMIT) && status.out_free;
	end

	a_tick_enters_mul1: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |=> state_q == psv_pkg::ST_MUL1)
		else $error("tick transfer did not start the pipeline");

	a_mul1_to_mul2: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == psv_pkg::ST_MUL1 |=> state_q == psv_pkg::ST_MUL2)
		else $error("pipeline step skipped");

	a_commit_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> state_q == psv_pkg::ST_IDLE)
		else $error("commit did not release the input side");

endmodule

@@ rtl/core/psv_dpath.sv @@
// Datapath of the plucked string voice: delay store, damping and allpass
// multipliers, envelope, tick counter and output register. Depends on psv_pkg.
module psv_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  psv_pkg::cfg_t     cfg,
	input  psv_pkg::cmd_t     cmd,
	output psv_pkg::status_t  status,
	input  logic [47:0]       in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [15:0]       out_data,
	output logic [0:0]        out_user
);

	logic signed [psv_pkg::SAMPLE_W-1:0] store_mem [psv_pkg::MAX_DELAY];

	logic [psv_pkg::ADDR_W-1:0]          rd_pos_q;
	logic signed [psv_pkg::SAMPLE_W-1:0] ap_in_q;
	logic signed [psv_pkg::SAMPLE_W-1:0] ap_out_q;
	logic [15:0]                         env_q;
	logic [psv_pkg::CNT_W-1:0]           cnt_q;
	logic                                ringing_q;
	logic                                out_valid_q;
	logic signed [psv_pkg::SAMPLE_W-1:0] out_sample_q;
	logic                                out_ring_q;

	logic [psv_pkg::ADDR_W-1:0]          pos_s1;
	logic [psv_pkg::ADDR_W-1:0]          nxt_s1;
	logic signed [psv_pkg::SAMPLE_W-1:0] cur_s1;
	logic signed [psv_pkg::SAMPLE_W-1:0] nval_s1;
	logic signed [33:0]                  prod1_s2;
	logic [15:0]                         env_s2;
	logic [psv_pkg::CNT_W-1:0]           cnt_s2;
	logic signed [33:0]                  prod2_s3;
	logic signed [psv_pkg::SAMPLE_W-1:0] damped_s3;

	logic [psv_pkg::ADDR_W-1:0]          slot;
	logic signed [psv_pkg::SAMPLE_W-1:0] exc;
	logic [14:0]                         amp;

	logic [psv_pkg::LEN_W-1:0]           len_eff;
	logic [psv_pkg::ADDR_W-1:0]          pos_eff;
	logic [psv_pkg::LEN_W-1:0]           nxt_wide;
	logic [psv_pkg::ADDR_W-1:0]          nxt_eff;

	logic signed [16:0]                  pair_sum;
	logic signed [33:0]                  prod1;
	logic [15:0]                         mag;
	logic [31:0]                         env_prod;
	logic [15:0]                         env_dec;

	logic signed [34:0]                  rnd1;
	logic signed [psv_pkg::SAMPLE_W-1:0] damped;
	logic signed [16:0]                  ap_diff;
	logic signed [33:0]                  prod2;

	logic signed [34:0]                  rnd2;
	logic signed [19:0]                  ap_sum;
	logic signed [psv_pkg::SAMPLE_W-1:0] ap_val;
	logic                                ring_end;

	assign slot = in_data[11:0];
	assign exc  = in_data[27:12];
	assign amp  = in_data[42:28];

	// read address selection at tick transfer
	always_comb begin
		len_eff = cfg.delay_length;
		if (len_eff < psv_pkg::LEN_MIN) len_eff = psv_pkg::LEN_MIN;
		if (len_eff > psv_pkg::LEN_MAX) len_eff = psv_pkg::LEN_MAX;
		pos_eff = rd_pos_q;
		if ({1'b0, rd_pos_q} >= len_eff) pos_eff = '0;
		nxt_wide = {1'b0, pos_eff} + 13'd1;
		nxt_eff  = (nxt_wide >= len_eff) ? '0 : nxt_wide[psv_pkg::ADDR_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr) begin
			store_mem[slot] <= exc;
		end else if (cmd.commit && ringing_q) begin
			store_mem[pos_s1] <= ap_val;
		end
		if (cmd.rd_en) begin
			cur_s1  <= store_mem[pos_eff];
			nval_s1 <= store_mem[nxt_eff];
			pos_s1  <= pos_eff;
			nxt_s1  <= nxt_eff;
		end
	end

	// stage 2: damping product, envelope and counter
	always_comb begin
		pair_sum = 17'(cur_s1) + 17'(nval_s1);
		prod1    = $signed({1'b0, cfg.damping}) * pair_sum;
		mag      = cur_s1[15] ? 16'(~cur_s1 + 16'sd1) : cur_s1;
		env_prod = 32'(env_q) * 32'(psv_pkg::DECAY_Q16);
		env_dec  = env_prod[31:16];
	end

	always_ff @(posedge clk) begin
		prod1_s2 <= prod1;
		env_s2   <= (mag > env_dec) ? mag : env_dec;
		cnt_s2   <= (cnt_q < psv_pkg::CNT_SAT) ? cnt_q + 24'd1 : cnt_q;
	end

	// stage 3: round and clamp, allpass product
	always_comb begin
		rnd1    = 35'(prod1_s2) + 35'sd65536;
		damped  = psv_pkg::sat_sample(20'($signed(rnd1[34:17])));
		ap_diff = 17'(damped) - 17'(ap_out_q);
		prod2   = $signed({1'b0, cfg.allpass_coeff}) * ap_diff;
	end

	always_ff @(posedge clk) begin
		prod2_s3  <= prod2;
		damped_s3 <= damped;
	end

	// commit: allpass output, ring end test
	always_comb begin
		rnd2     = 35'(prod2_s3) + 35'sd32768;
		ap_sum   = 20'($signed(rnd2[34:16])) + 20'(ap_in_q);
		ap_val   = psv_pkg::sat_sample(ap_sum);
		ring_end = (cnt_s2 >= cfg.max_ring) ||
			((cnt_s2 >= cfg.min_ring) && (env_s2 < {1'b0, cfg.silence_floor}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pos_q    <= '0;
			ap_in_q     <= '0;
			ap_out_q    <= '0;
			env_q       <= '0;
			cnt_q       <= '0;
			ringing_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				rd_pos_q  <= '0;
				ap_in_q   <= '0;
				ap_out_q  <= '0;
				env_q     <= {1'b0, amp};
				cnt_q     <= '0;
				ringing_q <= 1'b1;
			end else if (cmd.commit && ringing_q) begin
				rd_pos_q  <= nxt_s1;
				ap_in_q   <= damped_s3;
				ap_out_q  <= ap_val;
				env_q     <= env_s2;
				cnt_q     <= cnt_s2;
				ringing_q <= !ring_end;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_sample_q <= ringing_q ? cur_s1 : '0;
			out_ring_q   <= ringing_q && !ring_end;
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign out_data        = out_sample_q;
	assign out_user        = out_ring_q;

	a_silent_tick_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !ringing_q) |=> (out_sample_q == '0 && !out_ring_q))
		else $error("silent tick produced a nonzero result");

	a_ring_drops_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(ringing_q) |-> $past(cmd.commit))
		else $error("ringing ended outside a tick commit");

	a_commit_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> status.out_free)
		else $error("result committed over an untaken one");

endmodule

@@ rtl/core/plucked_string_synth_voice_unit.sv @@
// Plucked string voice: a Karplus-Strong string with a delay store, a
// damping stage, a tuning allpass, an envelope follower and a ring counter.
//
// Usage:
//  Input stream (s_axis): tuser selects load, start or tick; tdata carries
//  slot, excitation sample and amplitude. Load writes one delay slot; start
//  clears the filter state, position and counter and seeds the envelope.
//  Neither produces a result. Each tick produces one result on m_axis:
//  tdata is the output sample, tuser[0] says the string still rings.
//  Each tick passes through the read, damping multiply, allpass multiply and
//  write-back steps, the last through the single write port of the delay
//  store; a new tick is taken only after the last one has committed. Load
//  and start are applied at their transfer. s_axis_tready is low while a
//  tick is in flight.
//  A finished result waits in the output register while the next item is
//  taken; if it is still untaken when the next tick completes, that tick
//  holds in its last step until m_axis_tready rises.
//  Reset clears the filter state, envelope, counter and ringing flag and
//  loads the register defaults; delay store contents are undefined until loaded.
//  The user writes APB registers only while the block is idle; not enforced.
module plucked_string_synth_voice_unit (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // [11:0] slot_index, [27:12] excitation_sample,
	                                    // [42:28] amplitude, [47:43] zero
	input  logic [1:0]  s_axis_tuser,   // [1:0] kind
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] sample_out
	output logic [0:0]  m_axis_tuser    // [0] still_ringing
);

	psv_pkg::cfg_t    cfg;
	psv_pkg::cmd_t    cmd;
	psv_pkg::status_t status;

	psv_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	psv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_kind  (s_axis_tuser),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	psv_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.status    (status),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

endmodule
